FILE: hdl/bpa_pkg.sv
// Shared types, codes and default sizes for the bitmap page allocator.
// No dependencies; used by bitmap_page_allocator.
`default_nettype none

package bpa_pkg;

	// fixed field widths
	localparam int ADDR_W   = 48;
	localparam int REQ_CNT_W = 11;

	// default sizing
	localparam int NUM_PAGES_DEF  = 1024;
	localparam int PAGE_SHIFT_DEF = 12;
	localparam int WORD_BITS_DEF  = 64;

	// request operation codes
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	// response status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	// configuration register indexes
	localparam logic REG_REGION_BASE = 1'b0;

	typedef struct packed {
		logic                 func;
		logic [REQ_CNT_W-1:0] page_count;
		logic [ADDR_W-1:0]    free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] page_address;
	} rsp_t;

endpackage

`default_nettype wire

FILE: hdl/bpa_ram.sv
// Single-port RAM with registered read data.
// No dependencies; holds the used-page bitmap words.
`default_nettype none

module bpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic [AW-1:0]    addr,
	input  wire logic             we,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/bitmap_page_allocator.sv
// First-fit page allocator over a used-page bitmap kept in one RAM.
// Allocate scans the bitmap word by word (free or full words skip in one step, mixed words
// are scanned bit by bit), then marks the found run word by word with read-modify-write.
// Free clears its run word by word; a request refused on its count goes straight to the response.
// One request at a time; the shared bit scanner and RAM port set the rate.
// Reset: async active low; a clearing pass then writes MAP_WORDS zero words before ready.
`default_nettype none

module bitmap_page_allocator #(
	parameter int NUM_PAGES  = bpa_pkg::NUM_PAGES_DEF,
	parameter int PAGE_SHIFT = bpa_pkg::PAGE_SHIFT_DEF,
	parameter int WORD_BITS  = bpa_pkg::WORD_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request channel
	input  wire logic         req_valid,
	output logic              req_ready,
	input  wire bpa_pkg::req_t req,
	// response channel
	output logic              rsp_valid,
	input  wire logic         rsp_ready,
	output bpa_pkg::rsp_t     rsp,
	// configuration port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [63:0]  pwdata,
	output logic      [63:0]  prdata,
	output logic              pready
);

	import bpa_pkg::*;

	localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	// WORD_BITS is a power of two: a page index splits into word (high) and bit (low)
	localparam int BW        = $clog2(WORD_BITS);
	localparam int PIDX_W    = $clog2(NUM_PAGES + 1);
	localparam int CNT_W     = (PIDX_W > REQ_CNT_W) ? PIDX_W : REQ_CNT_W;
	localparam int IDX_W     = ADDR_W - PAGE_SHIFT;

	// sequencer states
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CHECK = 4'd2;
	localparam logic [3:0] S_FCHK  = 4'd3;
	localparam logic [3:0] S_FETCH = 4'd5;
	localparam logic [3:0] S_LOAD  = 4'd6;
	localparam logic [3:0] S_SCAN  = 4'd7;
	localparam logic [3:0] S_RD    = 4'd8;
	localparam logic [3:0] S_MOD   = 4'd9;
	localparam logic [3:0] S_ADDR  = 4'd10;
	localparam logic [3:0] S_FIN   = 4'd11;

	logic [3:0]           state_q;
	logic [ADDR_W-1:0]    base_q;
	logic                 func_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ADDR_W-1:0]    faddr_q;
	logic [ADDR_W-1:0]    diff_q;
	logic [PIDX_W-1:0]    p_q;
	logic [CNT_W-1:0]     run_q;      // free run length while scanning, pages left while marking
	logic [AW-1:0]        w_q;        // word cursor
	logic [BW-1:0]        b_q;        // bit cursor
	logic [AW-1:0]        sw_q;       // start of current free run
	logic [BW-1:0]        sb_q;
	logic [WORD_BITS-1:0] data_q;
	logic [PIDX_W-1:0]    first_q;
	logic [1:0]           status_q;
	logic [ADDR_W-1:0]    paddr_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// RAM port
	logic [AW-1:0]        ram_addr;
	logic                 ram_we;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WORD_BITS-1:0] ram_rdata;

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.addr (ram_addr),
		.we   (ram_we),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// configuration register
	logic cfg_wr;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[3] == REG_REGION_BASE) begin
			prdata = {{(64 - ADDR_W){1'b0}}, base_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_wr && paddr[3] == REG_REGION_BASE) begin
			base_q <= pwdata[ADDR_W-1:0];
		end
	end

	// handshakes
	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// response register takes a new word when it is empty or being drained
	logic rsp_load;
	assign rsp_load = (state_q == S_FIN) && (!rsp_valid_q || rsp_ready);

	// read-modify-write mask for the marking and clearing passes
	logic [CNT_W:0]       mask_hi;
	logic [WORD_BITS-1:0] mask;
	logic [CNT_W-1:0]     room;
	always_comb begin
		mask_hi = (CNT_W+1)'(b_q) + (CNT_W+1)'(run_q);
		for (int j = 0; j < WORD_BITS; j++) begin
			mask[j] = (BW'(j) >= b_q) && ((CNT_W+1)'(j) < mask_hi);
		end
		room = CNT_W'(WORD_BITS) - CNT_W'(b_q);
	end

	// scan and free-check helpers
	logic [ADDR_W-1:0] aligned;
	logic [IDX_W-1:0]  idx;
	logic [IDX_W-1:0]  limit;
	logic              full_word;
	logic              cur_bit;
	logic              last_bit;
	always_comb begin
		aligned   = faddr_q & ~ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
		idx       = diff_q[ADDR_W-1:PAGE_SHIFT];
		limit     = IDX_W'(CNT_W'(NUM_PAGES) - cnt_q);
		full_word = ((PIDX_W+1)'(p_q) + (PIDX_W+1)'(WORD_BITS)) <= (PIDX_W+1)'(NUM_PAGES);
		cur_bit   = data_q[b_q];
		last_bit  = (b_q == BW'(WORD_BITS - 1)) || (p_q + PIDX_W'(1) == PIDX_W'(NUM_PAGES));
	end

	// RAM access per state
	always_comb begin
		ram_addr  = w_q;
		ram_we    = 1'b0;
		ram_wdata = '0;
		case (state_q)
			S_CLR: begin
				ram_we = 1'b1;
			end
			S_MOD: begin
				ram_we    = 1'b1;
				ram_wdata = (func_q == FN_ALLOC) ? (ram_rdata | mask) : (ram_rdata & ~mask);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			w_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				// zero the bitmap after reset
				S_CLR: begin
					w_q <= w_q + AW'(1);
					if (w_q == AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid) begin
						func_q  <= req.func;
						cnt_q   <= CNT_W'(req.page_count);
						faddr_q <= req.free_address;
						state_q <= S_CHECK;
					end
				end
				// range checks, then either scan or start the free path
				S_CHECK: begin
					paddr_q <= '0;
					if (cnt_q == '0 || cnt_q > CNT_W'(NUM_PAGES)) begin
						status_q <= ST_INVALID;
						state_q  <= S_FIN;
					end else if (func_q == FN_ALLOC) begin
						p_q     <= '0;
						run_q   <= '0;
						w_q     <= '0;
						b_q     <= '0;
						sw_q    <= '0;
						sb_q    <= '0;
						state_q <= S_FETCH;
					end else if (aligned < base_q) begin
						status_q <= ST_INVALID;
						state_q  <= S_FIN;
					end else begin
						diff_q  <= aligned - base_q;
						state_q <= S_FCHK;
					end
				end
				// end check, then page index to word and bit
				S_FCHK: begin
					if (idx > limit) begin
						status_q <= ST_INVALID;
						state_q  <= S_FIN;
					end else begin
						w_q     <= idx[AW+BW-1:BW];
						b_q     <= idx[BW-1:0];
						run_q   <= cnt_q;
						state_q <= S_RD;
					end
				end
				S_FETCH: begin
					if (p_q == PIDX_W'(NUM_PAGES)) begin
						status_q <= ST_NOSPACE;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_LOAD;
					end
				end
				// whole-word fast paths, else bit scan (bit cursor is zero here)
				S_LOAD: begin
					data_q <= ram_rdata;
					if (full_word && ram_rdata == '0) begin
						if ((CNT_W+1)'(run_q) + (CNT_W+1)'(WORD_BITS) >= (CNT_W+1)'(cnt_q)) begin
							first_q <= p_q - PIDX_W'(run_q);
							w_q     <= sw_q;
							b_q     <= sb_q;
							run_q   <= cnt_q;
							state_q <= S_RD;
						end else begin
							run_q   <= run_q + CNT_W'(WORD_BITS);
							p_q     <= p_q + PIDX_W'(WORD_BITS);
							w_q     <= w_q + AW'(1);
							state_q <= S_FETCH;
						end
					end else if (full_word && (&ram_rdata)) begin
						run_q   <= '0;
						p_q     <= p_q + PIDX_W'(WORD_BITS);
						w_q     <= w_q + AW'(1);
						sw_q    <= w_q + AW'(1);
						sb_q    <= '0;
						state_q <= S_FETCH;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!cur_bit && run_q + CNT_W'(1) == cnt_q) begin
						first_q <= p_q + PIDX_W'(1) - PIDX_W'(cnt_q);
						w_q     <= sw_q;
						b_q     <= sb_q;
						run_q   <= cnt_q;
						state_q <= S_RD;
					end else begin
						if (cur_bit) begin
							run_q <= '0;
							if (b_q == BW'(WORD_BITS - 1)) begin
								sw_q <= w_q + AW'(1);
								sb_q <= '0;
							end else begin
								sw_q <= w_q;
								sb_q <= b_q + BW'(1);
							end
						end else begin
							run_q <= run_q + CNT_W'(1);
						end
						p_q <= p_q + PIDX_W'(1);
						if (last_bit) begin
							b_q     <= '0;
							w_q     <= w_q + AW'(1);
							state_q <= S_FETCH;
						end else begin
							b_q <= b_q + BW'(1);
						end
					end
				end
				// mark or clear the run word by word: read in S_RD, then write in S_MOD
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (run_q <= room) begin
						if (func_q == FN_ALLOC) begin
							state_q <= S_ADDR;
						end else begin
							status_q <= ST_DONE;
							state_q  <= S_FIN;
						end
					end else begin
						run_q   <= run_q - room;
						w_q     <= w_q + AW'(1);
						b_q     <= '0;
						state_q <= S_RD;
					end
				end
				S_ADDR: begin
					paddr_q  <= base_q + (ADDR_W'(first_q) << PAGE_SHIFT);
					status_q <= ST_DONE;
					state_q  <= S_FIN;
				end
				// hand the word to the response register once it is free
				S_FIN: begin
					if (rsp_load) begin
						rsp_q.status       <= status_q;
						rsp_q.page_address <= paddr_q;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	// only a successful allocation carries an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_DONE) |-> (rsp.page_address == '0))
		else $error("failed response carries a nonzero address");

	// the scan stops as soon as a run reaches the requested count
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN || state_q == S_LOAD || state_q == S_FETCH) |-> (run_q < cnt_q))
		else $error("free run reached count without ending the scan");

	// a new response word follows only the finishing state
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_FIN))
		else $error("response raised outside the finishing state");
`endif

endmodule

`default_nettype wire
